### rtl/core/fcfs_schedule_metrics_unit_assert.svh
// assertion macros shared by the scheduling metrics rtl
`ifndef FCFS_SCHEDULE_METRICS_UNIT_ASSERT_SVH
`define FCFS_SCHEDULE_METRICS_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// expression must hold at every clock edge outside reset
`define FCFS_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define FCFS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FCFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FCFS_ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define FCFS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define FCFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/core/fcfs_pkg.sv
// shared types, constants and width helpers for the scheduling metrics unit
`timescale 1ns / 1ps

package fcfs_pkg;

  localparam int MAX_PROCS = 16;
  localparam int TIME_BITS = 16;

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  // schedule clock never passes max arrival plus all bursts
  localparam int CLK_W = TIME_BITS + CNT_W;

  localparam int FIELD_W = 16;
  localparam int COMP_W  = 21;
  localparam int TAT_W   = 20;
  localparam int WAIT_W  = 20;
  localparam int TOT_W   = 24;

  typedef logic [TIME_BITS-1:0] tick_t;
  typedef logic [CLK_W-1:0]     sched_t;

  typedef struct packed {
    logic [FIELD_W-1:0] proc_id;
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] burst;
    logic               batch_end;
  } fcfs_req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] out_id;
    logic [FIELD_W-1:0] out_arrival;
    logic [FIELD_W-1:0] out_burst;
    logic [COMP_W-1:0]  completion;
    logic [TAT_W-1:0]   turnaround;
    logic [WAIT_W-1:0]  waiting;
    logic               final_res;
    logic [TOT_W-1:0]   turnaround_total;
    logic [TOT_W-1:0]   waiting_total;
    logic               overflowed;
  } fcfs_res_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic init;
    logic fetch;
    logic calc;
  } fcfs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_proc;
  } fcfs_stat_t;

  function automatic tick_t field_to_tick(logic [FIELD_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[TIME_BITS-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] tick_to_field(tick_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[FIELD_W-1:0];
  endfunction

  function automatic sched_t tick_to_sched(tick_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[CLK_W-1:0];
  endfunction

  function automatic logic [TOT_W-1:0] tick_to_tot(tick_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[TOT_W-1:0];
  endfunction

  function automatic logic [TOT_W-1:0] sched_to_tot(sched_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[TOT_W-1:0];
  endfunction

  function automatic logic [COMP_W-1:0] sched_to_comp(sched_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[COMP_W-1:0];
  endfunction

  function automatic logic [TAT_W-1:0] sched_to_tat(sched_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[TAT_W-1:0];
  endfunction

endpackage

### rtl/core/fcfs_ctrl.sv
// sequencer for load, fetch and calculate steps of the scheduler
`timescale 1ns / 1ps

module fcfs_ctrl import fcfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       batch_end,
  input  fcfs_stat_t stat,
  output fcfs_cmd_t  cmd,
  output logic       busy
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_CALC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (batch_end) begin
            cmd.init   = 1'b1;
            state_next = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = stat.last_proc ? ST_IDLE : ST_FETCH;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

### rtl/core/fcfs_dpath.sv
// sorted process cell chain, schedule clock, metric arithmetic and result register
`timescale 1ns / 1ps
`include "fcfs_schedule_metrics_unit_assert.svh"

module fcfs_dpath import fcfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  fcfs_req_t  req,
  input  fcfs_cmd_t  cmd,
  output fcfs_stat_t stat,
  output logic       res_valid,
  output fcfs_res_t  res
);

  logic [FIELD_W-1:0] id_cell  [MAX_PROCS];
  tick_t              arr_cell [MAX_PROCS];
  tick_t              bur_cell [MAX_PROCS];

  logic [CNT_W-1:0]   loaded_count;
  logic               drop_flag;
  logic [IDX_W-1:0]   proc_idx;

  tick_t              new_arr;
  tick_t              new_bur;
  logic               full;
  logic               do_insert;
  logic [MAX_PROCS-1:0] gt;

  sched_t             now;
  logic [TOT_W-1:0]   tat_total;
  logic [TOT_W-1:0]   wait_total;

  logic [FIELD_W-1:0] cur_id;
  tick_t              cur_arr;
  tick_t              cur_bur;
  sched_t             start_time;

  sched_t             fetch_arr;
  sched_t             comp;
  sched_t             wt;
  sched_t             tat;
  logic [TOT_W-1:0]   tat_total_next;
  logic [TOT_W-1:0]   wait_total_next;

  assign new_arr   = field_to_tick(req.arrival);
  assign new_bur   = field_to_tick(req.burst);
  assign full      = (loaded_count == CNT_W'(MAX_PROCS));
  assign do_insert = cmd.load && !full;

  // stored entries later than the new arrival move up one cell
  always_comb begin
    for (int i = 0; i < MAX_PROCS; i++) begin
      gt[i] = (CNT_W'(i) < loaded_count) && (arr_cell[i] > new_arr);
    end
  end

  for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
    if (g == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (do_insert && (gt[0] || (loaded_count == '0))) begin
          id_cell[0]  <= req.proc_id;
          arr_cell[0] <= new_arr;
          bur_cell[0] <= new_bur;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (do_insert) begin
          if (gt[g-1]) begin
            id_cell[g]  <= id_cell[g-1];
            arr_cell[g] <= arr_cell[g-1];
            bur_cell[g] <= bur_cell[g-1];
          end else if (gt[g] || (loaded_count == CNT_W'(g))) begin
            id_cell[g]  <= req.proc_id;
            arr_cell[g] <= new_arr;
            bur_cell[g] <= new_bur;
          end
        end
      end
    end
  end

  assign stat.last_proc = ((CNT_W'(proc_idx) + CNT_W'(1)) == loaded_count);

  // fetch step: read cell and resolve idle gap
  assign fetch_arr = tick_to_sched(arr_cell[proc_idx]);

  // calc step
  assign comp = start_time + tick_to_sched(cur_bur);
  assign wt   = start_time - tick_to_sched(cur_arr);
  assign tat  = wt + tick_to_sched(cur_bur);
  assign tat_total_next  = tat_total + sched_to_tot(wt) + tick_to_tot(cur_bur);
  assign wait_total_next = wait_total + sched_to_tot(wt);

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      drop_flag    <= 1'b0;
      proc_idx     <= '0;
      res_valid    <= 1'b0;
    end else begin
      res_valid <= cmd.calc;
      if (cmd.load) begin
        if (full) begin
          drop_flag <= 1'b1;
        end else begin
          loaded_count <= loaded_count + CNT_W'(1);
        end
      end
      if (cmd.init) begin
        proc_idx <= '0;
      end else if (cmd.calc) begin
        if (stat.last_proc) begin
          loaded_count <= '0;
          drop_flag    <= 1'b0;
          proc_idx     <= '0;
        end else begin
          proc_idx <= proc_idx + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      now        <= '0;
      tat_total  <= '0;
      wait_total <= '0;
    end
    if (cmd.fetch) begin
      cur_id     <= id_cell[proc_idx];
      cur_arr    <= arr_cell[proc_idx];
      cur_bur    <= bur_cell[proc_idx];
      start_time <= (now < fetch_arr) ? fetch_arr : now;
    end
    if (cmd.calc) begin
      now                  <= comp;
      tat_total            <= tat_total_next;
      wait_total           <= wait_total_next;
      res.out_id           <= cur_id;
      res.out_arrival      <= tick_to_field(cur_arr);
      res.out_burst        <= tick_to_field(cur_bur);
      res.completion       <= sched_to_comp(comp);
      res.turnaround       <= sched_to_tat(tat);
      res.waiting          <= sched_to_tat(wt);
      res.final_res        <= stat.last_proc;
      res.turnaround_total <= stat.last_proc ? tat_total_next : '0;
      res.waiting_total    <= stat.last_proc ? wait_total_next : '0;
      res.overflowed       <= drop_flag;
    end
  end

  `FCFS_ASSERT_ALWAYS(a_count_bound, clk, rst, loaded_count <= CNT_W'(MAX_PROCS), "count past capacity")
  `FCFS_ASSERT_NEXT(a_strobe_follows_calc, clk, rst, cmd.calc, res_valid, "calc gave no result strobe")
  `FCFS_ASSERT_NEXT(a_batch_clears, clk, rst, cmd.calc && stat.last_proc, loaded_count == '0 && !drop_flag, "batch state not cleared")
  `FCFS_ASSERT_IMPLIES(a_drop_only_when_full, clk, rst, $rose(drop_flag), $past(loaded_count) == CNT_W'(MAX_PROCS), "drop without full store")

endmodule

### rtl/core/fcfs_schedule_metrics_unit.sv
// top level of the first-come-first-serve schedule metrics unit
`timescale 1ns / 1ps

// usage
//   request channel: drive req and raise start; a request is taken at a rising
//   edge with start high and busy low. each request loads one process into a
//   chain of 16 cells kept sorted by arrival (equal arrivals keep load order).
//   loads may follow back to back while busy is low.
//   a request with batch_end set starts the schedule: busy stays high until
//   every stored process (1..16) has its result; for each process in order a
//   fetch step reads its cell and a calculate step registers its result with
//   res_valid, so no new request is taken until the batch is done.
//   result channel: res is valid for exactly the one cycle in which res_valid
//   is high; the receiver cannot stall, so every result must be taken then.
//   the last result has final_res set and carries the batch turnaround and
//   waiting sums; requests past capacity are dropped and flag overflowed.
//   reset (rst, synchronous) empties the chain and clears the drop flag;
//   cell contents are not cleared and are never read before being loaded.
module fcfs_schedule_metrics_unit import fcfs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  fcfs_req_t req,
  output logic      res_valid,
  output fcfs_res_t res
);

  fcfs_cmd_t  cmd;
  fcfs_stat_t stat;

  // sequencer: idle / fetch / calculate
  fcfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .batch_end (req.batch_end),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  // cell chain, schedule clock, sums and the result register
  fcfs_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule
